### design/cpu8_alu_with_flags_defines.svh
// Assertion macros for the cpu8_alu_with_flags block.
`ifndef CPU8_ALU_WITH_FLAGS_DEFINES_SVH
`define CPU8_ALU_WITH_FLAGS_DEFINES_SVH

`ifndef SYNTH
// Check a property on every clock edge outside reset.
`define C8_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("c8alu assertion failed");
// Check a property on every clock edge, reset included.
`define C8_ASSERT_ALWAYS(lbl, prop) \
   lbl: assert property (@(posedge clock) prop) \
      else $error("c8alu assertion failed");
`else
`define C8_ASSERT(lbl, prop)
`define C8_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

### design/c8alu_pkg.sv
// Package with operation codes, flag positions and item types of the 8-bit ALU.
`timescale 1ns / 1ps
package c8alu_pkg;

   localparam int ActionWidth = 5;
   localparam int ByteWidth   = 8;
   localparam int WordWidth   = 16;
   localparam int BitIdxWidth = 3;
   localparam int FlagWidth   = 4;

   // flag bit positions
   localparam int FlagZ = 3;
   localparam int FlagN = 2;
   localparam int FlagH = 1;
   localparam int FlagC = 0;

   localparam logic [ByteWidth-1:0] DaaHighAdj = 8'h60;
   localparam logic [ByteWidth-1:0] DaaLowAdj  = 8'h06;
   localparam logic [ByteWidth-1:0] DaaLimit   = 8'h99;

   typedef enum logic [ActionWidth-1:0] {
      OP_ADD   = 5'd0,
      OP_ADC   = 5'd1,
      OP_SUB   = 5'd2,
      OP_SBC   = 5'd3,
      OP_AND   = 5'd4,
      OP_OR    = 5'd5,
      OP_XOR   = 5'd6,
      OP_CP    = 5'd7,
      OP_INC   = 5'd8,
      OP_DEC   = 5'd9,
      OP_DAA   = 5'd10,
      OP_CPL   = 5'd11,
      OP_SCF   = 5'd12,
      OP_CCF   = 5'd13,
      OP_RLC   = 5'd14,
      OP_RL    = 5'd15,
      OP_RRC   = 5'd16,
      OP_RR    = 5'd17,
      OP_SLA   = 5'd18,
      OP_SRA   = 5'd19,
      OP_SRL   = 5'd20,
      OP_SWAP  = 5'd21,
      OP_BIT   = 5'd22,
      OP_RES   = 5'd23,
      OP_SET   = 5'd24,
      OP_ADD16 = 5'd25,
      OP_ADDSP = 5'd26,
      OP_INC16 = 5'd27,
      OP_DEC16 = 5'd28
   } action_type;

   typedef struct packed {
      logic [ActionWidth-1:0] action;
      logic [ByteWidth-1:0]   byte_left;
      logic [ByteWidth-1:0]   byte_right;
      logic [WordWidth-1:0]   word_left;
      logic [WordWidth-1:0]   word_right;
      logic [BitIdxWidth-1:0] bit_index;
      logic [FlagWidth-1:0]   flags_in;
   } req_type;

   typedef struct packed {
      logic [ByteWidth-1:0] byte_result;
      logic [WordWidth-1:0] word_result;
      logic [FlagWidth-1:0] flags_out;
      logic                 write_back;
   } rsp_type;

endpackage

### design/c8alu_if.sv
// Valid/ready channel interfaces for ALU requests and results.
`timescale 1ns / 1ps
interface c8alu_req_if
   import c8alu_pkg::*;
();
   logic                   valid;
   logic                   ready;
   logic [ActionWidth-1:0] action;
   logic [ByteWidth-1:0]   byte_left;
   logic [ByteWidth-1:0]   byte_right;
   logic [WordWidth-1:0]   word_left;
   logic [WordWidth-1:0]   word_right;
   logic [BitIdxWidth-1:0] bit_index;
   logic [FlagWidth-1:0]   flags_in;

   modport source (
      output valid, action, byte_left, byte_right, word_left, word_right,
             bit_index, flags_in,
      input  ready
   );
   modport sink (
      input  valid, action, byte_left, byte_right, word_left, word_right,
             bit_index, flags_in,
      output ready
   );
endinterface

interface c8alu_rsp_if
   import c8alu_pkg::*;
();
   logic                 valid;
   logic                 ready;
   logic [ByteWidth-1:0] byte_result;
   logic [WordWidth-1:0] word_result;
   logic [FlagWidth-1:0] flags_out;
   logic                 write_back;

   modport source (
      output valid, byte_result, word_result, flags_out, write_back,
      input  ready
   );
   modport sink (
      input  valid, byte_result, word_result, flags_out, write_back,
      output ready
   );
endinterface

### design/c8alu_core.sv
// Combinational ALU datapath: result bytes, words and flags for one item.
`timescale 1ns / 1ps
module c8alu_core
   import c8alu_pkg::*;
(
   input  req_type req,
   output rsp_type rsp
);

   logic [ByteWidth-1:0] a;
   logic [ByteWidth-1:0] b;
   logic [FlagWidth-1:0] fi;
   logic                 cin;
   logic                 carry_use;
   logic [8:0]           sum9;
   logic [4:0]           sum_nib;
   logic [8:0]           dif9;
   logic [4:0]           dif_nib;
   logic [ByteWidth-1:0] inc8;
   logic [ByteWidth-1:0] dec8;
   logic                 daa_hi;
   logic                 daa_lo;
   logic [ByteWidth-1:0] daa_mid;
   logic [ByteWidth-1:0] daa_add;
   logic [ByteWidth-1:0] daa_sub;
   logic [ByteWidth-1:0] bit_mask;
   logic [16:0]          add16_sum;
   logic [12:0]          add16_low;
   logic [WordWidth-1:0] sp_sum;
   logic [4:0]           sp_nib;
   logic [8:0]           sp_byte;
   logic [ByteWidth-1:0] r;
   logic [WordWidth-1:0] w;
   logic [FlagWidth-1:0] f;
   logic                 wb;

   assign a   = req.byte_left;
   assign b   = req.byte_right;
   assign fi  = req.flags_in;
   assign cin = fi[FlagC];

   // carry enters only for adc and sbc
   assign carry_use = (action_type'(req.action) == OP_ADC ||
                       action_type'(req.action) == OP_SBC) ? cin : 1'b0;

   assign sum9    = {1'b0, a} + {1'b0, b} + {8'd0, carry_use};
   assign sum_nib = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, carry_use};
   assign dif9    = {1'b0, a} - {1'b0, b} - {8'd0, carry_use};
   assign dif_nib = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, carry_use};

   assign inc8 = a + 8'd1;
   assign dec8 = a - 8'd1;

   // decimal adjust, add and subtract forms
   assign daa_hi  = cin || (a > DaaLimit);
   assign daa_mid = a + (daa_hi ? DaaHighAdj : 8'd0);
   assign daa_lo  = fi[FlagH] || (a[3:0] > 4'd9);
   assign daa_add = daa_mid + (daa_lo ? DaaLowAdj : 8'd0);
   assign daa_sub = a - (cin ? DaaHighAdj : 8'd0) - (fi[FlagH] ? DaaLowAdj : 8'd0);

   assign bit_mask = 8'd1 << req.bit_index;

   assign add16_sum = {1'b0, req.word_left} + {1'b0, req.word_right};
   assign add16_low = {1'b0, req.word_left[11:0]} + {1'b0, req.word_right[11:0]};

   // signed offset to the stack pointer, flags from the low byte
   assign sp_sum  = req.word_left + {{8{b[7]}}, b};
   assign sp_nib  = {1'b0, req.word_left[3:0]} + {1'b0, b[3:0]};
   assign sp_byte = {1'b0, req.word_left[7:0]} + {1'b0, b};

   always_comb begin
      r  = a;
      w  = '0;
      f  = fi;
      wb = 1'b1;
      case (action_type'(req.action))
         OP_ADD, OP_ADC: begin
            r = sum9[7:0];
            f = {sum9[7:0] == 8'd0, 1'b0, sum_nib[4], sum9[8]};
         end
         OP_SUB, OP_SBC: begin
            r = dif9[7:0];
            f = {dif9[7:0] == 8'd0, 1'b1, dif_nib[4], dif9[8]};
         end
         OP_CP: begin
            wb = 1'b0;
            f  = {dif9[7:0] == 8'd0, 1'b1, dif_nib[4], dif9[8]};
         end
         OP_AND: begin
            r = a & b;
            f = {(a & b) == 8'd0, 1'b0, 1'b1, 1'b0};
         end
         OP_OR: begin
            r = a | b;
            f = {(a | b) == 8'd0, 3'b000};
         end
         OP_XOR: begin
            r = a ^ b;
            f = {(a ^ b) == 8'd0, 3'b000};
         end
         OP_INC: begin
            r = inc8;
            f = {inc8 == 8'd0, 1'b0, a[3:0] == 4'hF, cin};
         end
         OP_DEC: begin
            r = dec8;
            f = {dec8 == 8'd0, 1'b1, a[3:0] == 4'h0, cin};
         end
         OP_DAA: begin
            if (fi[FlagN]) begin
               r = daa_sub;
               f = {daa_sub == 8'd0, 1'b1, 1'b0, cin};
            end else begin
               r = daa_add;
               f = {daa_add == 8'd0, 1'b0, 1'b0, daa_hi};
            end
         end
         OP_CPL: begin
            r = ~a;
            f = {fi[FlagZ], 1'b1, 1'b1, cin};
         end
         OP_SCF: f = {fi[FlagZ], 3'b001};
         OP_CCF: f = {fi[FlagZ], 2'b00, ~cin};
         OP_RLC: begin
            r = {a[6:0], a[7]};
            f = {a == 8'd0, 2'b00, a[7]};
         end
         OP_RL: begin
            r = {a[6:0], cin};
            f = {{a[6:0], cin} == 8'd0, 2'b00, a[7]};
         end
         OP_RRC: begin
            r = {a[0], a[7:1]};
            f = {a == 8'd0, 2'b00, a[0]};
         end
         OP_RR: begin
            r = {cin, a[7:1]};
            f = {{cin, a[7:1]} == 8'd0, 2'b00, a[0]};
         end
         OP_SLA: begin
            r = {a[6:0], 1'b0};
            f = {a[6:0] == 7'd0, 2'b00, a[7]};
         end
         OP_SRA: begin
            r = {a[7], a[7:1]};
            f = {a[7:1] == 7'd0, 2'b00, a[0]};
         end
         OP_SRL: begin
            r = {1'b0, a[7:1]};
            f = {a[7:1] == 7'd0, 2'b00, a[0]};
         end
         OP_SWAP: begin
            r = {a[3:0], a[7:4]};
            f = {a == 8'd0, 3'b000};
         end
         OP_BIT: begin
            wb = 1'b0;
            f  = {(a & bit_mask) == 8'd0, 1'b0, 1'b1, cin};
         end
         OP_RES: r = a & ~bit_mask;
         OP_SET: r = a | bit_mask;
         OP_ADD16: begin
            r = '0;
            w = add16_sum[15:0];
            f = {fi[FlagZ], 1'b0, add16_low[12], add16_sum[16]};
         end
         OP_ADDSP: begin
            r = '0;
            w = sp_sum;
            f = {2'b00, sp_nib[4], sp_byte[8]};
         end
         OP_INC16: begin
            r = '0;
            w = req.word_left + 16'd1;
         end
         OP_DEC16: begin
            r = '0;
            w = req.word_left - 16'd1;
         end
         default: wb = 1'b0;
      endcase
   end

   assign rsp.byte_result = r;
   assign rsp.word_result = w;
   assign rsp.flags_out   = f;
   assign rsp.write_back  = wb;

endmodule

### design/cpu8_alu_with_flags.sv
// Top level of the 8-bit ALU with flags: input register, datapath, result register.
`timescale 1ns / 1ps
`include "cpu8_alu_with_flags_defines.svh"
// 8-bit CPU ALU with Z, N, H and C flags. Each request item carries an
// operation code, two bytes, two words, a bit index and the current flags;
// each response item returns the byte and word results, the new flags and a
// write-back enable (low for compare, bit test and undefined codes). Flags an
// operation leaves alone are passed through. Exactly one response per
// request, in order. Timing: a request is captured in the input register,
// evaluated in one pass of the datapath and lands in the result register,
// which drives the response; the block takes one item per cycle unless
// the response side stalls. The two registers form a two-deep pipeline:
// a stalled response side fills both stages before req_ch.ready drops.
// There is no configuration and no state between items.
module cpu8_alu_with_flags
   import c8alu_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   c8alu_req_if.sink     req_ch,
   c8alu_rsp_if.source   rsp_ch
);

   req_type req_in;
   req_type s1_req_ff;
   logic    s1_valid_ff;
   logic    s1_valid_in;
   rsp_type core_rsp;
   rsp_type rsp_data_ff;
   logic    rsp_valid_ff;
   logic    rsp_valid_in;
   logic    out_ready;
   logic    in_ready;
   logic    req_take;

   // Result register can load when empty or when its item is leaving.
   assign out_ready = !rsp_valid_ff || rsp_ch.ready;
   // Input register can load when empty or when its item moves on.
   assign in_ready  = !s1_valid_ff || out_ready;
   assign req_take  = req_ch.valid && in_ready;

   assign req_ch.ready = in_ready;

   assign req_in = '{
      action:     req_ch.action,
      byte_left:  req_ch.byte_left,
      byte_right: req_ch.byte_right,
      word_left:  req_ch.word_left,
      word_right: req_ch.word_right,
      bit_index:  req_ch.bit_index,
      flags_in:   req_ch.flags_in
   };

   // Advance the stage valids: fill on acceptance, drop when drained.
   always_comb begin
      s1_valid_in  = s1_valid_ff;
      rsp_valid_in = rsp_valid_ff;
      if (in_ready) begin
         s1_valid_in = req_ch.valid;
      end
      if (out_ready) begin
         rsp_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers: hold while the stage behind them is stalled.
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_req_ff <= req_in;
      end
      if (out_ready && s1_valid_ff) begin
         rsp_data_ff <= core_rsp;
      end
   end

   c8alu_core u_core (
      .req (s1_req_ff),
      .rsp (core_rsp)
   );

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.byte_result = rsp_data_ff.byte_result;
   assign rsp_ch.word_result = rsp_data_ff.word_result;
   assign rsp_ch.flags_out   = rsp_data_ff.flags_out;
   assign rsp_ch.write_back  = rsp_data_ff.write_back;

   // Reset empties both pipeline stages.
   `C8_ASSERT_ALWAYS(a_reset_empties, reset |=> !s1_valid_ff && !rsp_valid_ff)
   // An item in the input register moves to the result register when it may.
   `C8_ASSERT(a_stage_advance, s1_valid_ff && out_ready |=> rsp_valid_ff)
   // Compare never asks for write-back.
   `C8_ASSERT(a_no_wb_cp, s1_valid_ff && s1_req_ff.action == OP_CP |-> !core_rsp.write_back)
   // Bit test never asks for write-back.
   `C8_ASSERT(a_no_wb_bit, s1_valid_ff && s1_req_ff.action == OP_BIT |-> !core_rsp.write_back)
   // An empty input stage always accepts.
   `C8_ASSERT(a_empty_accepts, !s1_valid_ff |-> req_ch.ready)

endmodule
